### src/smx_pkg.sv
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types, constants and the exponential table for the softmax row
// normalizer.
// ----------------------------------------------------------------------------
package smx_pkg;

    localparam int LOGIT_W   = 16;
    localparam int PROB_W    = 17;
    localparam int CLASS_W   = 4;
    localparam int FRAC_BITS = 8;
    localparam int TAB_DEPTH = 256;
    localparam int EXP_W     = 17;
    localparam int U_W       = LOGIT_W + 1;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam int PROD_W    = U_W + 17 + 1;
    localparam int V_W       = PROD_W - (24 - FRAC_BITS);
    localparam int QUOT_W    = 17;

    typedef struct packed {
        logic signed [LOGIT_W-1:0] logit;
        logic                      row_end;
    } smx_item_t;

    typedef struct packed {
        logic [PROB_W-1:0]  probability;
        logic [CLASS_W-1:0] class_index;
        logic               run_end;
        logic               row_overflow;
    } smx_result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXP_RD,
        ST_EXP_MUL,
        ST_EXP_WR,
        ST_DIV_RD,
        ST_DIV_LOAD,
        ST_DIV_STEP,
        ST_EMIT
    } smx_state_t;

    typedef struct packed {
        logic load;
        logic exp_mul;
        logic exp_wr;
        logic div_load;
        logic div_step;
        logic emit;
        logic idx_inc;
        logic idx_clr;
        logic row_clr;
    } smx_cmd_t;

    typedef struct packed {
        logic last_elem;
        logic div_last;
    } smx_status_t;

    typedef logic [EXP_W-1:0] smx_exp_tab_t [TAB_DEPTH];

    // Floor square root of a 64-bit value
    function automatic logic [63:0] smx_isqrt(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] b;
        x   = x_in;
        res = 64'd0;
        b   = 64'd1 << 62;
        while (b > x)
        begin
            b = b >> 2;
        end
        while (b != 64'd0)
        begin
            if (x >= res + b)
            begin
                x   = x - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Build 2^(-k/256) in Q1.16 from repeated square roots of one half
    function automatic smx_exp_tab_t smx_build_table();
        smx_exp_tab_t tab;
        logic [63:0]  roots [FRAC_BITS];
        logic [63:0]  r;
        logic [127:0] p;
        r = 64'd1 << 31;
        for (int j = FRAC_BITS; j > 0; j--)
        begin
            r = smx_isqrt(r << 32);
            roots[j-1] = r;
        end
        for (int k = 0; k < TAB_DEPTH; k++)
        begin
            p = 128'd1 << 32;
            for (int j = FRAC_BITS; j > 0; j--)
            begin
                if (((k >> (j - 1)) & 1) != 0)
                begin
                    p = (p * {64'd0, roots[j-1]} + (128'd1 << 31)) >> 32;
                end
            end
            tab[k] = EXP_W'((p + 128'd32768) >> 16);
        end
        return tab;
    endfunction

    localparam smx_exp_tab_t EXP_TABLE = smx_build_table();

endpackage

### src/smx_ram.sv
// ----------------------------------------------------------------------------
// smx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smx_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### src/smx_ctrl.sv
// ----------------------------------------------------------------------------
// smx_ctrl
// Sequencer: collects logits, then walks the exponential pass and the
// per-element division pass.
// ----------------------------------------------------------------------------
module smx_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                row_end,
    input  smx_pkg::smx_status_t status,
    output smx_pkg::smx_cmd_t    cmd,
    output logic                busy
);
    import smx_pkg::*;

    smx_state_t state_reg;
    smx_state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && row_end)
                begin
                    state_next = ST_EXP_RD;
                end
            end
            ST_EXP_RD:   state_next = ST_EXP_MUL;
            ST_EXP_MUL:  state_next = ST_EXP_WR;
            ST_EXP_WR:   state_next = status.last_elem ? ST_DIV_RD : ST_EXP_RD;
            ST_DIV_RD:   state_next = ST_DIV_LOAD;
            ST_DIV_LOAD: state_next = ST_DIV_STEP;
            ST_DIV_STEP: state_next = status.div_last ? ST_EMIT : ST_DIV_STEP;
            ST_EMIT:     state_next = status.last_elem ? ST_IDLE : ST_DIV_RD;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_EXP_MUL:
            begin
                cmd.exp_mul = 1'b1;
            end
            ST_EXP_WR:
            begin
                cmd.exp_wr  = 1'b1;
                cmd.idx_clr = status.last_elem;
                cmd.idx_inc = !status.last_elem;
            end
            ST_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
            end
            ST_DIV_STEP:
            begin
                cmd.div_step = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit    = 1'b1;
                cmd.row_clr = status.last_elem;
                cmd.idx_inc = !status.last_elem;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### src/smx_datapath.sv
// ----------------------------------------------------------------------------
// smx_datapath
// Logit and exponential stores, running max, exponential unit, sum and
// bit-serial restoring divider.
// ----------------------------------------------------------------------------
module smx_datapath #(
    parameter int MAX_CLASSES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  smx_pkg::smx_item_t   item,
    input  smx_pkg::smx_cmd_t    cmd,
    output smx_pkg::smx_status_t status,
    output logic                 result_valid,
    output smx_pkg::smx_result_t result
);
    import smx_pkg::*;

    localparam int AW    = $clog2(MAX_CLASSES);
    localparam int CW    = $clog2(MAX_CLASSES + 1);
    localparam int SW    = $clog2(MAX_CLASSES * 65536 + 1);
    localparam int NW    = ((SW > 33) ? SW : 33) + 1;
    localparam int SCW   = $clog2(QUOT_W);

    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              idx_reg;
    logic signed [LOGIT_W-1:0]  max_reg;
    logic                       ovf_reg;
    logic [SW-1:0]              sum_reg;
    logic [V_W-1:0]             v_reg;
    logic [SW-1:0]              rem_reg;
    logic [QUOT_W-1:0]          quot_reg;
    logic [SCW-1:0]             step_reg;
    logic                       valid_reg;
    smx_result_t                result_reg;

    logic [LOGIT_W-1:0]         logit_rdata;
    logic [EXP_W-1:0]           exp_rdata;
    logic                       store_we;
    logic signed [U_W-1:0]      u_val;
    logic [PROD_W-1:0]          prod;
    logic [V_W-FRAC_BITS-1:0]   n_val;
    logic [FRAC_BITS-1:0]       f_val;
    logic [EXP_W-1:0]           e_val;
    logic [NW-1:0]              num;
    logic [SW:0]                rem_shift;
    logic                       rem_ge;

    // Stores
    assign store_we = cmd.load && (count_reg < CW'(MAX_CLASSES));

    smx_ram #(.WIDTH(LOGIT_W), .DEPTH(MAX_CLASSES)) u_logit_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (item.logit),
        .raddr (idx_reg[AW-1:0]),
        .rdata (logit_rdata)
    );

    smx_ram #(.WIDTH(EXP_W), .DEPTH(MAX_CLASSES)) u_exp_ram (
        .clk   (clk),
        .we    (cmd.exp_wr),
        .waddr (idx_reg[AW-1:0]),
        .wdata (e_val),
        .raddr (idx_reg[AW-1:0]),
        .rdata (exp_rdata)
    );

    // Exponential: u * log2(e), then table entry shifted by the integer part
    assign u_val = U_W'(max_reg) - U_W'(signed'(logit_rdata));
    assign prod  = PROD_W'(unsigned'(u_val)) * PROD_W'(LOG2E_Q16)
                 + (PROD_W'(1) << (23 - FRAC_BITS));
    assign n_val = v_reg[V_W-1:FRAC_BITS];
    assign f_val = v_reg[FRAC_BITS-1:0];
    assign e_val = (n_val >= (V_W-FRAC_BITS)'(32)) ? '0 : (EXP_TABLE[f_val] >> n_val[4:0]);

    // Division numerator and one restoring step
    assign num       = (NW'(exp_rdata) << 16) + NW'(sum_reg >> 1);
    assign rem_shift = {rem_reg, quot_reg[QUOT_W-1]};
    assign rem_ge    = rem_shift >= (SW+1)'(sum_reg);

    assign status.last_elem = (idx_reg == count_reg - CW'(1));
    assign status.div_last  = (step_reg == SCW'(QUOT_W - 1));

    // Row control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            max_reg   <= {1'b1, {(LOGIT_W-1){1'b0}}};
            ovf_reg   <= 1'b0;
            sum_reg   <= '0;
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.emit;
            if (cmd.load)
            begin
                if (store_we)
                begin
                    count_reg <= count_reg + CW'(1);
                    if (item.logit > max_reg)
                    begin
                        max_reg <= item.logit;
                    end
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.exp_wr)
            begin
                sum_reg <= sum_reg + SW'(e_val);
            end
            if (cmd.div_load)
            begin
                step_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                step_reg <= step_reg + SCW'(1);
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (cmd.row_clr)
            begin
                count_reg <= '0;
                idx_reg   <= '0;
                max_reg   <= {1'b1, {(LOGIT_W-1){1'b0}}};
                ovf_reg   <= 1'b0;
                sum_reg   <= '0;
            end
        end
    end

    // Exponential pipeline and divider payload
    always_ff @(posedge clk)
    begin
        if (cmd.exp_mul)
        begin
            v_reg <= prod[PROD_W-1:24-FRAC_BITS];
        end
        if (cmd.div_load)
        begin
            rem_reg  <= SW'(num >> QUOT_W);
            quot_reg <= num[QUOT_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_ge ? SW'(rem_shift - (SW+1)'(sum_reg)) : SW'(rem_shift);
            quot_reg <= {quot_reg[QUOT_W-2:0], rem_ge};
        end
        if (cmd.emit)
        begin
            result_reg.probability  <= quot_reg;
            result_reg.class_index  <= CLASS_W'(idx_reg);
            result_reg.run_end      <= status.last_elem;
            result_reg.row_overflow <= ovf_reg;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

### src/softmax_row_normalizer_unit.sv
// ----------------------------------------------------------------------------
// softmax_row_normalizer_unit
// Max-subtracted fixed-point softmax over one row of Q7.8 logits.
// ----------------------------------------------------------------------------
// Usage:
//   Drive item (logit, row_end) with start high; the beat is taken on an edge
//   where busy is low. Non-final logits are stored, give no result and leave
//   busy low. Logits past MAX_CLASSES are dropped and flag row_overflow.
//   The beat with row_end set starts the computation: for the N stored
//   logits, an exponential pass over each element (RAM read, multiply, table
//   lookup and sum), then per element a division (RAM read, numerator load,
//   17 restoring steps, emit), after which busy drops.
//   Each probability appears on result for one cycle with result_valid high;
//   the receiver cannot stall, so it must take every beat.
//   Reset clears the row state and the controller; the stores need no clear.
// ----------------------------------------------------------------------------
module softmax_row_normalizer_unit #(
    parameter int MAX_CLASSES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  smx_pkg::smx_item_t   item,
    output logic                 busy,
    output logic                 result_valid,
    output smx_pkg::smx_result_t result
);
    import smx_pkg::*;

    smx_cmd_t    cmd;
    smx_status_t status;

    // Sequencer
    smx_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .row_end (item.row_end),
        .status  (status),
        .cmd     (cmd),
        .busy    (busy)
    );

    // Datapath
    smx_datapath #(.MAX_CLASSES(MAX_CLASSES)) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the softmax row normalizer: rows of logits are
// driven in bursts, each row's probabilities are predicted in fixed point and
// compared beat by beat with the block's output stream.
// ----------------------------------------------------------------------------
module tb;

    import smx_pkg::*;

    localparam int NCLS      = 16;
    localparam int CYC_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        start;
    smx_item_t   item;
    logic        busy;
    logic        result_valid;
    smx_result_t result;

    softmax_row_normalizer_unit #(.MAX_CLASSES(NCLS)) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    smx_item_t   logit_queue [$];
    smx_result_t prob_queue [$];
    logic [16:0] pow2_frac [256];
    logic signed [15:0] row_logits [NCLS];
    int          row_count;
    logic signed [15:0] row_max;
    logic        row_ovf;
    int          err_count;
    int          cyc;
    bit          stim_done;
    bit          hold_off;
    bit          beat_taken;
    int          burst_left;
    int          gap_left;

    // Build 2^(-k/256) in Q1.16 from repeated floor square roots
    function automatic logic [63:0] sqrt_floor(input logic [63:0] a);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = a;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic init_pow2();
        logic [63:0]  rt [8];
        logic [63:0]  r;
        logic [127:0] p;
        r = 64'd1 << 31;
        for (int j = 8; j > 0; j--)
        begin
            r = sqrt_floor(r << 32);
            rt[j-1] = r;
        end
        for (int k = 0; k < 256; k++)
        begin
            p = 128'd1 << 32;
            for (int j = 7; j >= 0; j--)
                if (k[j])
                    p = (p * rt[j] + (128'd1 << 31)) >> 32;
            pow2_frac[k] = 17'((p + 128'd32768) >> 16);
        end
    endtask

    function automatic logic [16:0] exp_of_gap(input logic [63:0] u);
        logic [63:0] v;
        v = (u * 64'd94548 + 64'd32768) >> 16;
        if ((v >> 8) >= 32)
            return 17'd0;
        return pow2_frac[v[7:0]] >> (v >> 8);
    endfunction

    // Absorb one accepted beat; on row end queue the row's probabilities
    task automatic predict_row(input smx_item_t it);
        logic [16:0] e [NCLS];
        logic [63:0] sum;
        smx_result_t r;
        if (row_count < NCLS)
        begin
            row_logits[row_count] = it.logit;
            if (it.logit > row_max)
                row_max = it.logit;
            row_count++;
        end
        else
            row_ovf = 1'b1;
        if (!it.row_end)
            return;
        sum = 0;
        for (int i = 0; i < row_count; i++)
        begin
            e[i] = exp_of_gap(64'(int'(row_max) - int'(row_logits[i])));
            sum += e[i];
        end
        for (int i = 0; i < row_count; i++)
        begin
            r.probability  = 17'((64'(e[i]) * 65536 + sum / 2) / sum);
            r.class_index  = 4'(i);
            r.run_end      = (i + 1 == row_count);
            r.row_overflow = row_ovf;
            prob_queue.insert(prob_queue.size(), r);
        end
        row_count = 0;
        row_max   = -16'sd32768;
        row_ovf   = 1'b0;
    endtask

    function automatic logic [15:0] rand_logit(input int spread);
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(0, 2 * spread) - spread);
        endcase
    endfunction

    task automatic add_row(input int len, input int spread);
        smx_item_t it;
        for (int i = 0; i < len; i++)
        begin
            it.logit   = rand_logit(spread);
            it.row_end = (i == len - 1);
            logit_queue.insert(logit_queue.size(), it);
        end
    endtask

    task automatic add_item(input logic [15:0] l, input logic e);
        smx_item_t it;
        it.logit   = l;
        it.row_end = e;
        logit_queue.insert(logit_queue.size(), it);
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Reset and stimulus
    initial
    begin
        int n;
        bit paused;
        rst_n     = 1'b0;
        err_count = 0;
        stim_done = 1'b0;
        hold_off  = 1'b0;
        paused    = 1'b0;
        row_count = 0;
        row_max   = -16'sd32768;
        row_ovf   = 1'b0;
        init_pow2();
        // directed: single element, extremes, equal values, full and overflow rows
        add_item(16'h8000, 1'b1);
        add_item(16'h7fff, 1'b1);
        add_item(16'h8000, 1'b0);
        add_item(16'h7fff, 1'b1);
        add_item(16'h0000, 1'b0);
        add_item(16'h0000, 1'b1);
        add_item(16'h0100, 1'b0);
        add_item(16'h0000, 1'b0);
        add_item(16'hff00, 1'b1);
        repeat (12) @(posedge clk);
        rst_n = 1'b1;
        add_row(16, 2048);
        add_row(18, 512);
        // random rows, mostly short
        n = 40;
        while (n < 260)
        begin
            int len;
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20)
                                              : $urandom_range(1, 6);
            if (!paused && n >= 130)
            begin
                wait (logit_queue.size() == 0 && !start && prob_queue.size() == 0);
                paused   = 1'b1;
                hold_off = 1'b1;
                repeat (60) @(posedge clk);
                hold_off = 1'b0;
            end
            add_row(len, $urandom_range(0, 1) ? 256 : 4096);
            n += len;
        end
        stim_done = 1'b1;
    end

    // Drive beats in bursts with random gaps
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            item       <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (start && !beat_taken)
        begin
            // hold the pending beat
        end
        else if (hold_off || logit_queue.size() == 0)
            start <= 1'b0;
        else if (gap_left > 0)
        begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else
        begin
            start <= 1'b1;
            item  <= logit_queue.pop_front();
            if (burst_left == 0)
            begin
                burst_left <= $urandom_range(0, 12);
                gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            else
                burst_left <= burst_left - 1;
        end
    end

    // Predict on accepted beats, check result beats
    always @(posedge clk)
    begin
        smx_result_t exp_r;
        if (rst_n)
        begin
            beat_taken = start && !busy;
            if (beat_taken)
                predict_row(item);
            if (result_valid)
            begin
                if (prob_queue.size() == 0)
                begin
                    $error("unexpected result beat %p", result);
                    err_count++;
                end
                else
                begin
                    exp_r = prob_queue.pop_front();
                    if (result.probability !== exp_r.probability)
                    begin
                        $error("probability exp %0d got %0d",
                               exp_r.probability, result.probability);
                        err_count++;
                    end
                    if (result.class_index !== exp_r.class_index)
                    begin
                        $error("class_index exp %0d got %0d",
                               exp_r.class_index, result.class_index);
                        err_count++;
                    end
                    if (result.run_end !== exp_r.run_end)
                    begin
                        $error("run_end exp %0d got %0d", exp_r.run_end, result.run_end);
                        err_count++;
                    end
                    if (result.row_overflow !== exp_r.row_overflow)
                    begin
                        $error("row_overflow exp %0d got %0d",
                               exp_r.row_overflow, result.row_overflow);
                        err_count++;
                    end
                end
            end
        end
        else
        begin
            beat_taken = 1'b0;
        end
    end

    // Watchdog
    initial
    begin
        cyc = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc > CYC_LIMIT)
            begin
                $display("[softmax_row_normalizer_unit] ERROR");
                $finish;
            end
        end
    end

    // End of run
    initial
    begin
        wait (stim_done);
        wait (logit_queue.size() == 0 && !start && prob_queue.size() == 0);
        repeat (500) @(posedge clk);
        if (err_count == 0 && prob_queue.size() == 0)
            $display("[softmax_row_normalizer_unit] OK");
        else
            $display("[softmax_row_normalizer_unit] ERROR");
        $finish;
    end

endmodule

### files.f
src/smx_pkg.sv
src/smx_ram.sv
src/smx_ctrl.sv
src/smx_datapath.sv
src/softmax_row_normalizer_unit.sv
tb/tb.sv
